[hw/rtl/cvl_pkg.sv]
// ---------------------------------------------------------------------------
// cvl_pkg: shared constants and types for the 3x3 line-buffered convolver
// Sizes, register indexes, the job record that travels from the front end to
// the arithmetic back end, and the coefficient extract.
// ---------------------------------------------------------------------------
package cvl_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int PIXEL_BITS     = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int KERNEL_DIM     = 3;
  localparam int KERNEL_TAPS    = KERNEL_DIM * KERNEL_DIM;
  localparam int INTERIOR_MIN   = KERNEL_DIM - 1;

  localparam int PIX_FIELD_W = 16;
  localparam int IN_DATA_W   = ((PIX_FIELD_W + 7) / 8) * 8;
  localparam int COEF_W      = 16;
  localparam int KROW_W      = KERNEL_DIM * COEF_W;
  localparam int DIM_W       = 11;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int FILL_W      = $clog2(MAX_WIDTH + 1);
  localparam int VALUE_W     = 22;
  localparam int OUT_FIELD_W = VALUE_W + COL_W + ROW_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;

  // unsigned pixel (zero-extended) times signed coefficient, then the sums
  localparam int PROD_W = PIXEL_BITS + 1 + COEF_W;
  localparam int RSUM_W = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_TOP    = 3'd0,
    CFG_KERNEL_MID    = 3'd1,
    CFG_KERNEL_BOTTOM = 3'd2,
    CFG_IMAGE_WIDTH   = 3'd3,
    CFG_IMAGE_HEIGHT  = 3'd4
  } cfg_idx_t;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // position of the pixel just taken and what it completes
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             interior;
    logic             border;
    logic             frame_last;
  } cvl_pos_t;

  // tap index is KERNEL_DIM * window column + kernel row
  typedef struct packed {
    pix_t [KERNEL_TAPS-1:0] tap;
    cvl_pos_t               pos;
  } cvl_job_t;

  function automatic logic signed [COEF_W-1:0] coef_at(input logic [KROW_W-1:0] krow,
                                                       input int k);
    coef_at = krow[k*COEF_W +: COEF_W];
  endfunction

endpackage

[hw/rtl/cvl_front.sv]
// ---------------------------------------------------------------------------
// cvl_front: pixel intake, frame position and line stores
// Tracks row and column, reads the two line stores at the column, classifies
// the pixel and hands a complete 3x3 window job to the queue.
// ---------------------------------------------------------------------------
module cvl_front import cvl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pix_t             pixel,
  input  logic [DIM_W-1:0] image_width,
  input  logic [DIM_W-1:0] image_height,
  output cvl_job_t         job,
  output logic             job_valid,
  input  logic             job_full
);

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [COL_W-1:0]  c, w_last;
  logic [ROW_W-1:0]  r, h_last;
  logic              c_is_last, r_is_last;
  logic              accept, push;
  logic [COL_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic [FILL_W-1:0] fill_r;
  cvl_pos_t          pos;

  logic              s1_v_r;
  logic              s1_hit_r;
  pix_t              s1_pix_r;
  cvl_pos_t          s1_pos_r;
  pix_t              rd_old_r, rd_new_r;
  pix_t              top_px, mid_px;
  pix_t              win_r [2*KERNEL_DIM];

  pix_t              older_mem [MAX_WIDTH];
  pix_t              newer_mem [MAX_WIDTH];

  always_comb begin
    w_eff = image_width;
    if (image_width < DIM_W'(KERNEL_DIM)) begin
      w_eff = DIM_W'(KERNEL_DIM);
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    h_eff = image_height;
    if (image_height < DIM_W'(KERNEL_DIM)) begin
      h_eff = DIM_W'(KERNEL_DIM);
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end
  end

  assign w_last = COL_W'(w_eff - DIM_W'(1));
  assign h_last = ROW_W'(h_eff - DIM_W'(1));

  // saturate a position left beyond a shrunk frame
  assign c = (DIM_W'(col_cnt_r) >= w_eff) ? w_last : col_cnt_r;
  assign r = (DIM_W'(row_cnt_r) >= h_eff) ? h_last : row_cnt_r;

  assign c_is_last = (c == w_last);
  assign r_is_last = (r == h_last);

  always_comb begin
    pos.col        = c;
    pos.row        = r;
    pos.interior   = (r >= ROW_W'(INTERIOR_MIN)) && (c >= COL_W'(INTERIOR_MIN));
    pos.border     = (r == '0) || r_is_last || (c == '0) || c_is_last;
    pos.frame_last = r_is_last && c_is_last;
    if (c_is_last) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = r_is_last ? '0 : r + ROW_W'(1);
    end else begin
      col_cnt_nxt = c + COL_W'(1);
      row_cnt_nxt = r;
    end
  end

  assign in_ready = !s1_v_r || !job_full;
  assign accept   = in_valid && in_ready;
  assign push     = s1_v_r && !job_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      fill_r    <= '0;
      s1_v_r    <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
        // columns are first written in ascending order, so a count marks them
        if (FILL_W'(c) == fill_r) begin
          fill_r <= fill_r + FILL_W'(1);
        end
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (push) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= pixel;
      s1_pos_r <= pos;
      s1_hit_r <= (FILL_W'(c) < fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_old_r <= older_mem[c];
    end
    if (push) begin
      older_mem[s1_pos_r.col] <= mid_px;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_new_r <= newer_mem[c];
    end
    if (push) begin
      newer_mem[s1_pos_r.col] <= s1_pix_r;
    end
  end

  // unwritten columns read as zero
  assign top_px = s1_hit_r ? rd_old_r : '0;
  assign mid_px = s1_hit_r ? rd_new_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2*KERNEL_DIM; i++) begin
        win_r[i] <= '0;
      end
    end else if (push) begin
      for (int i = 0; i < KERNEL_DIM; i++) begin
        win_r[i] <= win_r[KERNEL_DIM+i];
      end
      win_r[KERNEL_DIM]   <= top_px;
      win_r[KERNEL_DIM+1] <= mid_px;
      win_r[KERNEL_DIM+2] <= s1_pix_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 2*KERNEL_DIM; i++) begin
      job.tap[i] = win_r[i];
    end
    job.tap[2*KERNEL_DIM]   = top_px;
    job.tap[2*KERNEL_DIM+1] = mid_px;
    job.tap[2*KERNEL_DIM+2] = s1_pix_r;
    job.pos                 = s1_pos_r;
  end

  assign job_valid = s1_v_r;

endmodule

[hw/rtl/cvl_queue.sv]
// ---------------------------------------------------------------------------
// cvl_queue: short job queue between front end and back end
// Lets the front keep taking pixels while the arithmetic waits on the output.
// ---------------------------------------------------------------------------
module cvl_queue import cvl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cvl_job_t push_job,
  output logic     full,
  input  logic     pop,
  output cvl_job_t head,
  output logic     empty
);

  cvl_job_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hw/rtl/cvl_back.sv]
// ---------------------------------------------------------------------------
// cvl_back: multiply, accumulate and result emission
// Nine products, row sums, total and floor shift, then an output register
// that sends the interior result before the border result of the same job.
// ---------------------------------------------------------------------------
module cvl_back import cvl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cvl_job_t                  head,
  input  logic                      q_empty,
  output logic                      pop,
  input  logic [KROW_W-1:0]         kernel_top,
  input  logic [KROW_W-1:0]         kernel_mid,
  input  logic [KROW_W-1:0]         kernel_bottom,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] value,
  output logic [COL_W-1:0]          column,
  output logic [ROW_W-1:0]          row,
  output logic                      last_of_item,
  output logic                      frame_done
);

  logic [KROW_W-1:0]         krow [KERNEL_DIM];
  logic signed [PROD_W-1:0]  prod_nxt [KERNEL_TAPS];
  logic signed [RSUM_W-1:0]  rsum_nxt [KERNEL_DIM];
  logic signed [SUM_W-1:0]   total, total_sh;
  logic signed [PROD_W-1:0]  bprod_sh;

  logic                      m_v_r, a1_v_r, a2_v_r, o_v_r, o_sent_r;
  logic signed [PROD_W-1:0]  m_prod_r [KERNEL_TAPS];
  logic signed [PROD_W-1:0]  m_bprod_r, a1_bprod_r;
  logic signed [RSUM_W-1:0]  a1_rsum_r [KERNEL_DIM];
  logic signed [VALUE_W-1:0] a2_ival_r, a2_bval_r, o_ival_r, o_bval_r;
  cvl_pos_t                  m_pos_r, a1_pos_r, a2_pos_r, o_pos_r;

  logic                      m_rdy, a1_rdy, a2_rdy, o_rdy, o_last, use_int;

  assign krow[0] = kernel_top;
  assign krow[1] = kernel_mid;
  assign krow[2] = kernel_bottom;

  always_comb begin
    for (int k = 0; k < KERNEL_DIM; k++) begin
      for (int j = 0; j < KERNEL_DIM; j++) begin
        prod_nxt[KERNEL_DIM*k+j] = $signed({1'b0, head.tap[KERNEL_DIM*k+j]})
                                   * coef_at(krow[j], k);
      end
    end
    for (int j = 0; j < KERNEL_DIM; j++) begin
      rsum_nxt[j] = RSUM_W'(m_prod_r[j]) + RSUM_W'(m_prod_r[KERNEL_DIM+j])
                    + RSUM_W'(m_prod_r[2*KERNEL_DIM+j]);
    end
    total = SUM_W'(a1_rsum_r[0]) + SUM_W'(a1_rsum_r[1]) + SUM_W'(a1_rsum_r[2]);
    total_sh = total >>> COEF_FRAC_BITS;
    bprod_sh = a1_bprod_r >>> COEF_FRAC_BITS;
  end

  // the job holds two results only when interior and border both apply
  assign o_last = !(o_pos_r.interior && o_pos_r.border && !o_sent_r);
  assign o_rdy  = !o_v_r || (out_ready && o_last);
  assign a2_rdy = !a2_v_r || o_rdy;
  assign a1_rdy = !a1_v_r || a2_rdy;
  assign m_rdy  = !m_v_r || a1_rdy;
  assign pop    = !q_empty && m_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r    <= 1'b0;
      a1_v_r   <= 1'b0;
      a2_v_r   <= 1'b0;
      o_v_r    <= 1'b0;
      o_sent_r <= 1'b0;
    end else begin
      if (m_rdy) begin
        m_v_r <= !q_empty;
      end
      if (a1_rdy) begin
        a1_v_r <= m_v_r;
      end
      if (a2_rdy) begin
        a2_v_r <= a1_v_r;
      end
      if (o_rdy) begin
        // drop jobs that complete nothing
        o_v_r    <= a2_v_r && (a2_pos_r.interior || a2_pos_r.border);
        o_sent_r <= 1'b0;
      end else if (out_ready) begin
        o_sent_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy) begin
      for (int i = 0; i < KERNEL_TAPS; i++) begin
        m_prod_r[i] <= prod_nxt[i];
      end
      m_bprod_r <= $signed({1'b0, head.tap[KERNEL_TAPS-1]}) * coef_at(kernel_mid, 1);
      m_pos_r   <= head.pos;
    end
    if (a1_rdy) begin
      for (int j = 0; j < KERNEL_DIM; j++) begin
        a1_rsum_r[j] <= rsum_nxt[j];
      end
      a1_bprod_r <= m_bprod_r;
      a1_pos_r   <= m_pos_r;
    end
    if (a2_rdy) begin
      a2_ival_r <= total_sh[VALUE_W-1:0];
      a2_bval_r <= bprod_sh[VALUE_W-1:0];
      a2_pos_r  <= a1_pos_r;
    end
    if (o_rdy) begin
      o_ival_r <= a2_ival_r;
      o_bval_r <= a2_bval_r;
      o_pos_r  <= a2_pos_r;
    end
  end

  assign use_int      = o_pos_r.interior && !o_sent_r;
  assign out_valid    = o_v_r;
  assign value        = use_int ? o_ival_r : o_bval_r;
  assign column       = use_int ? o_pos_r.col - COL_W'(1) : o_pos_r.col;
  assign row          = use_int ? o_pos_r.row - ROW_W'(1) : o_pos_r.row;
  assign last_of_item = o_last;
  assign frame_done   = o_last && o_pos_r.frame_last;

endmodule

[hw/rtl/convolve_3x3_line_buffered_top.sv]
// ---------------------------------------------------------------------------
// convolve_3x3_line_buffered_top: 3x3 convolver over a raster pixel stream
// Configuration registers, front end, job queue and arithmetic back end.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : one unsigned pixel per transfer in raster order; the block keeps
//            its own row and column count and wraps at the frame end.
//   out_*  : results in completion order, each with its row and column. An
//            interior pixel completes when the pixel below-right of it arrives;
//            a border pixel is scaled by the centre coefficient at once. When
//            one pixel completes both, the interior result goes first.
//   cfg_*  : register writes, which the user makes only while no pixel is in
//            flight; the block itself does not enforce this.
// Throughput is one pixel per clock while the queue has room; a pixel that
// completes two results holds the output for both. A pixel passes the line
// store read register, the queue, and the multiply, row sum, total and output
// registers. The line stores need no clearing: a column fill count makes
// unwritten columns read as zero, so the block is ready right after reset,
// which also returns the frame position to row 0, column 0. When the receiver
// stalls, the back end holds, the four-entry queue fills, and in_tready falls.
// ---------------------------------------------------------------------------
module convolve_3x3_line_buffered_top import cvl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // pixel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // value, column, row, zero fill
  output logic                  out_tuser,  // last_of_item
  output logic                  out_tlast,  // frame_done
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KROW_W-1:0]     cfg_wdata
);

  logic [KROW_W-1:0]         kernel_top_r, kernel_mid_r, kernel_bottom_r;
  logic [DIM_W-1:0]          width_r, height_r;
  cvl_job_t                  job, head;
  logic                      job_valid, job_full, q_empty, pop;
  logic signed [VALUE_W-1:0] value;
  logic [COL_W-1:0]          column;
  logic [ROW_W-1:0]          row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_top_r    <= '0;
      kernel_mid_r    <= KROW_W'(1) << (COEF_W + COEF_FRAC_BITS);
      kernel_bottom_r <= '0;
      width_r         <= DIM_W'(MAX_WIDTH);
      height_r        <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KERNEL_TOP:    kernel_top_r    <= cfg_wdata;
        CFG_KERNEL_MID:    kernel_mid_r    <= cfg_wdata;
        CFG_KERNEL_BOTTOM: kernel_bottom_r <= cfg_wdata;
        CFG_IMAGE_WIDTH:   width_r         <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  height_r        <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  cvl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .pixel        (in_tdata[PIXEL_BITS-1:0]),
    .image_width  (width_r),
    .image_height (height_r),
    .job          (job),
    .job_valid    (job_valid),
    .job_full     (job_full)
  );

  cvl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (job),
    .full     (job_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  cvl_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .kernel_top    (kernel_top_r),
    .kernel_mid    (kernel_mid_r),
    .kernel_bottom (kernel_bottom_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .value         (value),
    .column        (column),
    .row           (row),
    .last_of_item  (out_tuser),
    .frame_done    (out_tlast)
  );

  assign out_tdata = OUT_DATA_W'({row, column, value});

endmodule

[tb/sv/convolve_3x3_line_buffered_sb_pkg.sv]
// ---------------------------------------------------------------------------
// convolve_3x3_line_buffered_sb_pkg: scoreboard for the 3x3 convolver
// Keeps its own copy of the line stores, the window, the frame position and
// the registers, works out the results of each accepted pixel and checks the
// results of the block against them in order.
// ---------------------------------------------------------------------------
package convolve_3x3_line_buffered_sb_pkg;
  import cvl_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               last_of_item;
    logic               frame_done;
  } conv_result_t;

  class convolver_scoreboard;
    logic [KROW_W-1:0] kernel_rows [KERNEL_DIM];
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    pix_t              store_older [MAX_WIDTH];
    pix_t              store_newer [MAX_WIDTH];
    pix_t              win_prev2 [KERNEL_DIM];
    pix_t              win_prev1 [KERNEL_DIM];
    int unsigned       col_pos;
    int unsigned       row_pos;
    conv_result_t      expected_results [$];
    int                mismatch_count;

    function void restart();
      kernel_rows[0] = '0;
      kernel_rows[1] = KROW_W'(1) << (COEF_W + COEF_FRAC_BITS);
      kernel_rows[2] = '0;
      width_reg  = DIM_W'(MAX_WIDTH);
      height_reg = DIM_W'(MAX_HEIGHT);
      foreach (store_older[i]) begin
        store_older[i] = '0;
        store_newer[i] = '0;
      end
      foreach (win_prev2[i]) begin
        win_prev2[i] = '0;
        win_prev1[i] = '0;
      end
      col_pos = 0;
      row_pos = 0;
      expected_results.delete();
      mismatch_count = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [KROW_W-1:0] val);
      case (idx)
        CFG_KERNEL_TOP:    kernel_rows[0] = val;
        CFG_KERNEL_MID:    kernel_rows[1] = val;
        CFG_KERNEL_BOTTOM: kernel_rows[2] = val;
        CFG_IMAGE_WIDTH:   width_reg = val[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  height_reg = val[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function longint tap_weight(logic [KROW_W-1:0] krow_bits, int k);
      logic signed [COEF_W-1:0] w;
      w = krow_bits[k*COEF_W +: COEF_W];
      return longint'(w);
    endfunction

    function void push_result(longint acc, int unsigned c, int unsigned r);
      conv_result_t res;
      longint       scaled;
      // arithmetic shift floors towards minus infinity
      scaled           = acc >>> COEF_FRAC_BITS;
      res.value        = scaled[VALUE_W-1:0];
      res.col          = c[COL_W-1:0];
      res.row          = r[ROW_W-1:0];
      res.last_of_item = 1'b0;
      res.frame_done   = 1'b0;
      expected_results.push_back(res);
    endfunction

    function void note_pixel(pix_t pix);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int          n_new;
      int          tail;
      longint      acc;
      pix_t        col3 [KERNEL_DIM];
      w = width_reg;
      h = height_reg;
      if (w < KERNEL_DIM) w = KERNEL_DIM;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < KERNEL_DIM) h = KERNEL_DIM;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      // saturate a position left beyond a shrunk frame
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;

      col3[0] = store_older[c];
      col3[1] = store_newer[c];
      col3[2] = pix;
      store_older[c] = store_newer[c];
      store_newer[c] = pix;

      n_new = 0;
      if (r >= INTERIOR_MIN && c >= INTERIOR_MIN) begin
        acc = 0;
        for (int j = 0; j < KERNEL_DIM; j++) begin
          acc += longint'(win_prev2[j]) * tap_weight(kernel_rows[j], 0);
          acc += longint'(win_prev1[j]) * tap_weight(kernel_rows[j], 1);
          acc += longint'(col3[j]) * tap_weight(kernel_rows[j], 2);
        end
        push_result(acc, c - 1, r - 1);
        n_new++;
      end
      if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
        push_result(longint'(pix) * tap_weight(kernel_rows[1], 1), c, r);
        n_new++;
      end

      for (int j = 0; j < KERNEL_DIM; j++) begin
        win_prev2[j] = win_prev1[j];
        win_prev1[j] = col3[j];
      end

      if (n_new > 0) begin
        tail = expected_results.size() - 1;
        expected_results[tail].last_of_item = 1'b1;
        if (r == h - 1 && c == w - 1) expected_results[tail].frame_done = 1'b1;
      end

      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic tuser, logic tlast);
      conv_result_t got;
      conv_result_t want;
      got.value        = data[VALUE_W-1:0];
      got.col          = data[VALUE_W +: COL_W];
      got.row          = data[VALUE_W+COL_W +: ROW_W];
      got.last_of_item = tuser;
      got.frame_done   = tlast;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, got value %0d col %0d row %0d last %0b frame %0b",
                 $time, $signed(got.value), got.col, got.row, got.last_of_item,
                 got.frame_done);
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
        mismatch_count++;
        $display("%0t: result mismatch: expected value %0d col %0d row %0d last %0b frame %0b",
                 $time, $signed(want.value), want.col, want.row, want.last_of_item,
                 want.frame_done);
        $display("%0t:                  got value %0d col %0d row %0d last %0b frame %0b",
                 $time, $signed(got.value), got.col, got.row, got.last_of_item,
                 got.frame_done);
      end
    endfunction
  endclass

endpackage

[tb/sv/convolve_3x3_line_buffered_top_tb.sv]
// ---------------------------------------------------------------------------
// convolve_3x3_line_buffered_top_tb: testbench of the 3x3 convolver
// Streams pixel frames of many sizes and kernels through the block, with
// random gaps on the input and stalls on the output, and checks each result
// against the scoreboard's prediction.
// ---------------------------------------------------------------------------
module convolve_3x3_line_buffered_top_tb
  import cvl_pkg::*, convolve_3x3_line_buffered_sb_pkg::*;
  ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS  = 800;
  localparam int          SETTLE_CYCLES = 12;
  localparam longint      TIMEOUT_NS    = 12_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam logic [COEF_W-1:0]    COEF_MAX      = 16'h7FFF;
  localparam logic [COEF_W-1:0]    COEF_MIN      = 16'h8000;
  localparam pix_t                 PIX_MAX       = 16'hFFFF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // pixel
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // value, column, row, zero fill
  logic                  out_tuser;       // last_of_item
  logic                  out_tlast;       // frame_done
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [KROW_W-1:0]     cfg_wdata = '0;

  convolver_scoreboard sb;
  int idle_pct  = 0;
  int stall_pct = 0;

  convolve_3x3_line_buffered_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // check results on each output transfer, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser, out_tlast);
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_pixel(input pix_t pix);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(pix);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KROW_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_register(idx, val);
    cfg_wr_en <= 1'b0;
  endtask

  // hold off until every expected result is in and the pipeline is empty
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int profile);
    case (profile)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 60; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 60; end
      default: begin idle_pct = 33; stall_pct = 33; end
    endcase
  endtask

  function automatic pix_t pick_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return PIX_MAX;
      default: return pix_t'($urandom_range(32'hFFFF));
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] pick_kernel_row();
    case ($urandom_range(7))
      0:       return {KERNEL_DIM{COEF_MAX}};
      1:       return {KERNEL_DIM{COEF_MIN}};
      default: return KROW_W'({$urandom, $urandom});
    endcase
  endfunction

  // size word with random bits above the register width
  function automatic logic [KROW_W-1:0] dim_word(input int unsigned dim);
    logic [KROW_W-1:0] word;
    word = KROW_W'({$urandom, $urandom});
    word[DIM_W-1:0] = dim[DIM_W-1:0];
    return word;
  endfunction

  initial begin : stimulus
    pix_t        first_row [6];
    int          random_items;
    int          phase;
    int          n_pix;
    int unsigned w;
    int unsigned h;

    first_row = '{PIX_MAX, PIX_MAX, 16'h0000, 16'h5555, 16'hAAAA, 16'h0001};
    sb = new;
    sb.restart();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: row 0 of a full-size frame, centre weight of one
    set_idling(0);
    foreach (first_row[i]) send_pixel(first_row[i]);
    drain_results();

    // shrink to 3x3 mid-row: the position saturates to the last column
    write_reg(CFG_SPARE_IDX, KROW_W'({$urandom, $urandom}));
    write_reg(CFG_KERNEL_TOP, {KERNEL_DIM{COEF_MAX}});
    write_reg(CFG_KERNEL_MID, {KERNEL_DIM{COEF_MAX}});
    write_reg(CFG_KERNEL_BOTTOM, {KERNEL_DIM{COEF_MAX}});
    write_reg(CFG_IMAGE_WIDTH, dim_word(3));
    write_reg(CFG_IMAGE_HEIGHT, dim_word(3));
    repeat (7) send_pixel(PIX_MAX);
    drain_results();

    // most negative sum on a full frame
    write_reg(CFG_KERNEL_TOP, {KERNEL_DIM{COEF_MIN}});
    write_reg(CFG_KERNEL_MID, {KERNEL_DIM{COEF_MIN}});
    write_reg(CFG_KERNEL_BOTTOM, {KERNEL_DIM{COEF_MIN}});
    repeat (9) send_pixel(PIX_MAX);
    drain_results();

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        2: begin w = MAX_WIDTH; h = 1; n_pix = 40; end
        5: begin w = 3; h = MAX_HEIGHT; n_pix = 60; end
        8: begin w = 0; h = 2; n_pix = 40; end
        11: begin w = 2047; h = 3; n_pix = 50; end
        default: begin
          w = $urandom_range(3, 12);
          h = $urandom_range(3, 10);
          n_pix = $urandom_range(20, 60);
        end
      endcase
      random_items += n_pix;
      write_reg(CFG_KERNEL_TOP, pick_kernel_row());
      write_reg(CFG_KERNEL_MID, pick_kernel_row());
      write_reg(CFG_KERNEL_BOTTOM, pick_kernel_row());
      write_reg(CFG_IMAGE_WIDTH, dim_word(w));
      write_reg(CFG_IMAGE_HEIGHT, dim_word(h));
      if (phase % 5 == 0) write_reg(CFG_SPARE_IDX, KROW_W'({$urandom, $urandom}));
      set_idling(phase % 4);
      repeat (n_pix) send_pixel(pick_pixel());
      drain_results();
      phase++;
    end

    set_idling(0);
    drain_results();
    if (sb.mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
hw/rtl/cvl_pkg.sv
hw/rtl/cvl_front.sv
hw/rtl/cvl_queue.sv
hw/rtl/cvl_back.sv
hw/rtl/convolve_3x3_line_buffered_top.sv
tb/sv/convolve_3x3_line_buffered_sb_pkg.sv
tb/sv/convolve_3x3_line_buffered_top_tb.sv
